### hw/rtl/psc_pkg.sv
// Shared types and codes for the packet steering classifier.
// Used by the config register file, the decision logic, the top level and the checker.
package psc_pkg;

    // Header field widths
    localparam int MacW  = 48;
    localparam int IpW   = 32;
    localparam int HashW = 32;

    localparam int InDataW  = 280;
    localparam int InUserW  = 2;
    localparam int OutDataW = 64;
    localparam int OutUserW = 2;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 48;

    // Register indexes
    localparam logic [CfgAddrW-1:0] REG_MODE         = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_GATEWAY_MAC  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_NET_ADDR     = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_NET_MASK     = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_SUB_MASK     = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_FIXED_TARGET = 3'd5;

    // Steering policies
    localparam logic [3:0] MODE_LINK      = 4'd0;
    localparam logic [3:0] MODE_LOCALLINK = 4'd1;
    localparam logic [3:0] MODE_DBLMAC    = 4'd2;
    localparam logic [3:0] MODE_VLAN      = 4'd3;
    localparam logic [3:0] MODE_P2P       = 4'd4;
    localparam logic [3:0] MODE_DBLIP     = 4'd5;
    localparam logic [3:0] MODE_LOCALNET  = 4'd6;
    localparam logic [3:0] MODE_FLOW      = 4'd7;
    localparam logic [3:0] MODE_FIXED     = 4'd8;
    localparam logic [3:0] MODE_RSS       = 4'd9;
    localparam logic [3:0] MODE_COUNTER   = 4'd10;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    localparam logic [MacW-1:0] MAC_ONES = {MacW{1'b1}};
    localparam logic [IpW-1:0]  IP_ONES  = {IpW{1'b1}};

    typedef enum logic [1:0] {
        ACT_DROP   = 2'd0,
        ACT_STEER  = 2'd1,
        ACT_DOUBLE = 2'd2,
        ACT_BCAST  = 2'd3
    } action_t;

    typedef struct packed {
        logic [3:0]      mode;
        logic [MacW-1:0] gateway_mac;
        logic [IpW-1:0]  net_addr;
        logic [IpW-1:0]  net_mask;
        logic [IpW-1:0]  sub_mask;
        logic [IpW-1:0]  fixed_target;
    } cfg_t;

    typedef struct packed {
        logic [MacW-1:0] dst_mac;
        logic [MacW-1:0] src_mac;
        logic            ip_present;
        logic [IpW-1:0]  src_ip;
        logic [IpW-1:0]  dst_ip;
        logic [7:0]      ip_proto;
        logic            l4_present;
        logic [15:0]     src_port;
        logic [15:0]     dst_port;
        logic [11:0]     vlan_id;
        logic [31:0]     rss_hash;
        logic [31:0]     packet_count;
    } hdr_t;

    typedef struct packed {
        action_t          action;
        logic [HashW-1:0] hash_a;
        logic [HashW-1:0] hash_b;
    } result_t;

endpackage

### hw/rtl/psc_cfg_regs.sv
// Configuration register file of the packet steering classifier.
// Depends on psc_pkg for register indexes and the cfg_t bundle.
module psc_cfg_regs
    import psc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= MODE_LINK;
            cfg_reg.gateway_mac  <= '0;
            cfg_reg.net_addr     <= '0;
            cfg_reg.net_mask     <= '0;
            cfg_reg.sub_mask     <= IP_ONES;
            cfg_reg.fixed_target <= '0;
        end
        else if (cfg_we)
        begin
            // ignore writes to unused indexes
            unique case (cfg_addr)
                REG_MODE:         cfg_reg.mode         <= cfg_wdata[3:0];
                REG_GATEWAY_MAC:  cfg_reg.gateway_mac  <= cfg_wdata[MacW-1:0];
                REG_NET_ADDR:     cfg_reg.net_addr     <= cfg_wdata[IpW-1:0];
                REG_NET_MASK:     cfg_reg.net_mask     <= cfg_wdata[IpW-1:0];
                REG_SUB_MASK:     cfg_reg.sub_mask     <= cfg_wdata[IpW-1:0];
                REG_FIXED_TARGET: cfg_reg.fixed_target <= cfg_wdata[IpW-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/psc_decide.sv
// Steering decision logic: one header and the configuration in, one decision out.
// Depends on psc_pkg for the header, config and result types.
module psc_decide
    import psc_pkg::*;
(
    input  cfg_t    cfg,
    input  hdr_t    hdr,
    output result_t res
);

    logic [15:0]    dh;
    logic [15:0]    sh;
    logic           mac_bc;
    logic           ip_bc;
    logic           s_in;
    logic           d_in;
    logic           l4_proto;
    logic [IpW-1:0] ip_xor;

    assign dh = hdr.dst_mac[47:32] ^ hdr.dst_mac[31:16] ^ hdr.dst_mac[15:0];
    assign sh = hdr.src_mac[47:32] ^ hdr.src_mac[31:16] ^ hdr.src_mac[15:0];
    assign mac_bc = (hdr.dst_mac == MAC_ONES) || (hdr.src_mac == MAC_ONES);
    assign ip_bc  = (hdr.src_ip == IP_ONES) || (hdr.dst_ip == IP_ONES);
    assign s_in   = (hdr.src_ip & cfg.net_mask) == cfg.net_addr;
    assign d_in   = (hdr.dst_ip & cfg.net_mask) == cfg.net_addr;
    assign l4_proto = (hdr.ip_proto == PROTO_TCP) || (hdr.ip_proto == PROTO_UDP);
    assign ip_xor = hdr.src_ip ^ hdr.dst_ip;

    always_comb
    begin
        res.action = ACT_DROP;
        res.hash_a = '0;
        res.hash_b = '0;
        unique case (cfg.mode)
            MODE_LINK:
            begin
                if (mac_bc)
                    res.action = ACT_BCAST;
                else
                begin
                    res.action = ACT_STEER;
                    res.hash_a = {16'd0, dh ^ sh};
                end
            end
            MODE_LOCALLINK:
            begin
                if (mac_bc)
                    res.action = ACT_BCAST;
                else if (hdr.dst_mac == cfg.gateway_mac)
                begin
                    res.action = ACT_STEER;
                    res.hash_a = {16'd0, sh};
                end
                else if (hdr.src_mac == cfg.gateway_mac)
                begin
                    res.action = ACT_STEER;
                    res.hash_a = {16'd0, dh};
                end
                else
                begin
                    res.action = ACT_DOUBLE;
                    res.hash_a = {16'd0, dh};
                    res.hash_b = {16'd0, sh};
                end
            end
            MODE_DBLMAC:
            begin
                if (mac_bc)
                    res.action = ACT_BCAST;
                else
                begin
                    res.action = ACT_DOUBLE;
                    res.hash_a = {16'd0, dh};
                    res.hash_b = {16'd0, sh};
                end
            end
            MODE_VLAN:
            begin
                if (hdr.vlan_id != '0)
                begin
                    res.action = ACT_STEER;
                    res.hash_a = {20'd0, hdr.vlan_id};
                end
            end
            MODE_P2P:
            begin
                if (hdr.ip_present)
                begin
                    if (ip_bc)
                        res.action = ACT_BCAST;
                    else
                    begin
                        res.action = ACT_STEER;
                        res.hash_a = ip_xor;
                    end
                end
            end
            MODE_DBLIP:
            begin
                if (hdr.ip_present)
                begin
                    if (ip_bc)
                        res.action = ACT_BCAST;
                    else
                    begin
                        res.action = ACT_DOUBLE;
                        res.hash_a = hdr.src_ip;
                        res.hash_b = hdr.dst_ip;
                    end
                end
            end
            MODE_LOCALNET:
            begin
                if (hdr.ip_present)
                begin
                    if (ip_bc)
                        res.action = ACT_BCAST;
                    else if (s_in && d_in)
                    begin
                        res.action = ACT_DOUBLE;
                        res.hash_a = hdr.src_ip & cfg.sub_mask;
                        res.hash_b = hdr.dst_ip & cfg.sub_mask;
                    end
                    else if (s_in)
                    begin
                        res.action = ACT_STEER;
                        res.hash_a = hdr.src_ip & cfg.sub_mask;
                    end
                    else if (d_in)
                    begin
                        res.action = ACT_STEER;
                        res.hash_a = hdr.dst_ip & cfg.sub_mask;
                    end
                end
            end
            MODE_FLOW:
            begin
                // no broadcast check on flows
                if (hdr.ip_present)
                begin
                    if (!l4_proto)
                    begin
                        res.action = ACT_STEER;
                        res.hash_a = ip_xor;
                    end
                    else if (hdr.l4_present)
                    begin
                        res.action = ACT_STEER;
                        res.hash_a = ip_xor ^ {16'd0, hdr.src_port} ^ {16'd0, hdr.dst_port};
                    end
                end
            end
            MODE_FIXED:
            begin
                res.action = ACT_STEER;
                res.hash_a = cfg.fixed_target;
            end
            MODE_RSS:
            begin
                res.action = ACT_STEER;
                res.hash_a = hdr.rss_hash;
            end
            MODE_COUNTER:
            begin
                res.action = ACT_STEER;
                res.hash_a = hdr.packet_count;
            end
            default:
            begin
                // undefined modes drop
                res.action = ACT_DROP;
            end
        endcase
    end

endmodule

### hw/rtl/packet_steering_classifier.sv
// Top level of the packet steering classifier: input register, decision, result register.
// Depends on psc_pkg, psc_cfg_regs and psc_decide.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata header fields, s_tuser presence flags
//  m_*       out  m_tvalid/m_tready    m_tdata hash_a/hash_b, m_tuser action
//  cfg_*     in   cfg_we               cfg_addr register index, cfg_wdata value
//
// One word per cycle sustained while m_tready stays high; an accepted header passes
// the input register and then the result register before it shows on m_*: the
// decision runs from the input register and loads the result register.
// Reset clears both valid flags and loads the register defaults (sub_mask all ones).
// A stalled result holds in the result register while the input register still
// takes one more word; s_tready drops only when both stages are full and m_tready is low.
module packet_steering_classifier
    import psc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // dst_mac, src_mac, src_ip, dst_ip, ip_proto, src_port, dst_port,
    // vlan_id, rss_hash, packet_count, 4 zero pad bits
    input  logic [InDataW-1:0]  s_tdata,
    // ip_present, l4_present
    input  logic [InUserW-1:0]  s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // hash_a, hash_b
    output logic [OutDataW-1:0] m_tdata,
    // action
    output logic [OutUserW-1:0] m_tuser,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    cfg_t    cfg;
    hdr_t    hdr_in;
    hdr_t    hdr_reg;
    result_t res_next;
    result_t res_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    out_load;

    psc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    always_comb
    begin
        hdr_in.dst_mac      = s_tdata[47:0];
        hdr_in.src_mac      = s_tdata[95:48];
        hdr_in.src_ip       = s_tdata[127:96];
        hdr_in.dst_ip       = s_tdata[159:128];
        hdr_in.ip_proto     = s_tdata[167:160];
        hdr_in.src_port     = s_tdata[183:168];
        hdr_in.dst_port     = s_tdata[199:184];
        hdr_in.vlan_id      = s_tdata[211:200];
        hdr_in.rss_hash     = s_tdata[243:212];
        hdr_in.packet_count = s_tdata[275:244];
        hdr_in.ip_present   = s_tuser[0];
        hdr_in.l4_present   = s_tuser[1];
    end

    // advance the result stage when it is empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            hdr_reg <= hdr_in;
        if (out_load && in_valid_reg)
            res_reg <= res_next;
    end

    psc_decide u_decide (
        .cfg (cfg),
        .hdr (hdr_reg),
        .res (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.hash_b, res_reg.hash_a};
    assign m_tuser  = res_reg.action;

endmodule

### hw/rtl/psc_checker.sv
// Port-level checks for the packet steering classifier, bound to the top level.
// Depends on psc_pkg for action codes and channel widths.
module psc_checker
    import psc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic [OutUserW-1:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // drop and broadcast carry no hashes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ACT_DROP || m_tuser == ACT_BCAST) |-> m_tdata == '0)
        else $error("hash set on drop or broadcast");

    // single steer leaves the second hash clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ACT_STEER |-> m_tdata[OutDataW-1:HashW] == '0)
        else $error("second hash set on single steer");

    // an empty result stage never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty result stage");

endmodule

bind packet_steering_classifier psc_checker u_psc_checker (.*);

### bench/packet_steering_classifier_checker.sv
// Checker for the packet steering classifier: watches the header, result and config ports,
// predicts each steering decision and compares it with the result words that come out.
// Depends on psc_pkg for the header, result and config types and the register and mode codes.
module packet_steering_classifier_checker
    import psc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,
    input  logic [InUserW-1:0]  s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OutDataW-1:0] m_tdata,
    input  logic [OutUserW-1:0] m_tuser,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [CfgDataW-1:0] cfg_wdata,
    output int                  errors,
    output int                  pending
);

    cfg_t    regs;
    result_t decisions_q[$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] mac_fold(input logic [MacW-1:0] mac);
        return mac[47:32] ^ mac[31:16] ^ mac[15:0];
    endfunction

    function automatic result_t steer_decision(input hdr_t h, input cfg_t c);
        result_t     r;
        logic [15:0] dh;
        logic [15:0] sh;
        logic        mac_bc;
        logic        ip_bc;
        logic        s_in;
        logic        d_in;
        r.action = ACT_DROP;
        r.hash_a = '0;
        r.hash_b = '0;
        dh     = mac_fold(h.dst_mac);
        sh     = mac_fold(h.src_mac);
        mac_bc = (h.dst_mac == MAC_ONES) || (h.src_mac == MAC_ONES);
        ip_bc  = (h.src_ip == IP_ONES) || (h.dst_ip == IP_ONES);
        s_in   = (h.src_ip & c.net_mask) == c.net_addr;
        d_in   = (h.dst_ip & c.net_mask) == c.net_addr;
        case (c.mode)
            MODE_LINK:
            begin
                if (mac_bc)
                    r.action = ACT_BCAST;
                else
                begin
                    r.action = ACT_STEER;
                    r.hash_a = {16'h0, dh ^ sh};
                end
            end
            MODE_LOCALLINK:
            begin
                if (mac_bc)
                    r.action = ACT_BCAST;
                else if (h.dst_mac == c.gateway_mac)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = {16'h0, sh};
                end
                else if (h.src_mac == c.gateway_mac)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = {16'h0, dh};
                end
                else
                begin
                    r.action = ACT_DOUBLE;
                    r.hash_a = {16'h0, dh};
                    r.hash_b = {16'h0, sh};
                end
            end
            MODE_DBLMAC:
            begin
                if (mac_bc)
                    r.action = ACT_BCAST;
                else
                begin
                    r.action = ACT_DOUBLE;
                    r.hash_a = {16'h0, dh};
                    r.hash_b = {16'h0, sh};
                end
            end
            MODE_VLAN:
            begin
                if (h.vlan_id != '0)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = {20'h0, h.vlan_id};
                end
            end
            MODE_P2P:
            begin
                if (h.ip_present && ip_bc)
                    r.action = ACT_BCAST;
                else if (h.ip_present)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = h.src_ip ^ h.dst_ip;
                end
            end
            MODE_DBLIP:
            begin
                if (h.ip_present && ip_bc)
                    r.action = ACT_BCAST;
                else if (h.ip_present)
                begin
                    r.action = ACT_DOUBLE;
                    r.hash_a = h.src_ip;
                    r.hash_b = h.dst_ip;
                end
            end
            MODE_LOCALNET:
            begin
                if (h.ip_present && ip_bc)
                    r.action = ACT_BCAST;
                else if (h.ip_present && s_in && d_in)
                begin
                    r.action = ACT_DOUBLE;
                    r.hash_a = h.src_ip & c.sub_mask;
                    r.hash_b = h.dst_ip & c.sub_mask;
                end
                else if (h.ip_present && s_in)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = h.src_ip & c.sub_mask;
                end
                else if (h.ip_present && d_in)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = h.dst_ip & c.sub_mask;
                end
            end
            MODE_FLOW:
            begin
                // non TCP/UDP traffic steers on the addresses alone, no broadcast check
                if (h.ip_present && h.ip_proto != PROTO_TCP && h.ip_proto != PROTO_UDP)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = h.src_ip ^ h.dst_ip;
                end
                else if (h.ip_present && h.l4_present)
                begin
                    r.action = ACT_STEER;
                    r.hash_a = h.src_ip ^ h.dst_ip ^ {16'h0, h.src_port} ^ {16'h0, h.dst_port};
                end
            end
            MODE_FIXED:
            begin
                r.action = ACT_STEER;
                r.hash_a = c.fixed_target;
            end
            MODE_RSS:
            begin
                r.action = ACT_STEER;
                r.hash_a = h.rss_hash;
            end
            MODE_COUNTER:
            begin
                r.action = ACT_STEER;
                r.hash_a = h.packet_count;
            end
            default:
            begin
                r.action = ACT_DROP;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hdr_t    hdr;
        result_t want;
        if (!rst_n)
        begin
            regs.mode         = MODE_LINK;
            regs.gateway_mac  = '0;
            regs.net_addr     = '0;
            regs.net_mask     = '0;
            regs.sub_mask     = IP_ONES;
            regs.fixed_target = '0;
            decisions_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MODE:         regs.mode         = cfg_wdata[3:0];
                    REG_GATEWAY_MAC:  regs.gateway_mac  = cfg_wdata[MacW-1:0];
                    REG_NET_ADDR:     regs.net_addr     = cfg_wdata[IpW-1:0];
                    REG_NET_MASK:     regs.net_mask     = cfg_wdata[IpW-1:0];
                    REG_SUB_MASK:     regs.sub_mask     = cfg_wdata[IpW-1:0];
                    REG_FIXED_TARGET: regs.fixed_target = cfg_wdata[IpW-1:0];
                    default:          ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (decisions_q.size() == 0)
                    report_mismatch("result word with no header pending", m_tdata, '0);
                else
                begin
                    want = decisions_q.pop_front();
                    if (m_tuser != want.action)
                        report_mismatch("action", 64'(m_tuser), 64'(want.action));
                    if (m_tdata[31:0] != want.hash_a)
                        report_mismatch("hash_a", 64'(m_tdata[31:0]), 64'(want.hash_a));
                    if (m_tdata[63:32] != want.hash_b)
                        report_mismatch("hash_b", 64'(m_tdata[63:32]), 64'(want.hash_b));
                end
            end
            if (s_tvalid && s_tready)
            begin
                hdr.dst_mac      = s_tdata[47:0];
                hdr.src_mac      = s_tdata[95:48];
                hdr.src_ip       = s_tdata[127:96];
                hdr.dst_ip       = s_tdata[159:128];
                hdr.ip_proto     = s_tdata[167:160];
                hdr.src_port     = s_tdata[183:168];
                hdr.dst_port     = s_tdata[199:184];
                hdr.vlan_id      = s_tdata[211:200];
                hdr.rss_hash     = s_tdata[243:212];
                hdr.packet_count = s_tdata[275:244];
                hdr.ip_present   = s_tuser[0];
                hdr.l4_present   = s_tuser[1];
                decisions_q.push_back(steer_decision(hdr, regs));
            end
            pending <= decisions_q.size();
        end
    end

endmodule

### bench/packet_steering_classifier_test.sv
// Top of the packet steering classifier bench: clock, reset, header and config stimulus,
// output back-pressure and the verdict.
// Depends on psc_pkg, the block itself and packet_steering_classifier_checker.
module packet_steering_classifier_test;
    import psc_pkg::*;

    localparam logic [CfgAddrW-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CfgAddrW-1:0] REG_UNUSED_HI = 3'd7;
    localparam logic [3:0]          MODE_UNDEF    = 4'hf;
    localparam logic [7:0]          PROTO_ICMP    = 8'd1;
    localparam int                  HOLD_CYCLES   = 300;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // dst_mac, src_mac, src_ip, dst_ip, ip_proto, src_port, dst_port,
    // vlan_id, rss_hash, packet_count, 4 zero pad bits
    logic [InDataW-1:0]  s_tdata;
    // ip_present, l4_present
    logic [InUserW-1:0]  s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // hash_a, hash_b
    logic [OutDataW-1:0] m_tdata;
    // action
    logic [OutUserW-1:0] m_tuser;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic [CfgDataW-1:0] cfg_wdata;

    int  errors;
    int  pending;
    int  n_sent;
    int  n_settings;
    bit  gaps_on;
    bit  hold_req;

    // current register values, used to bias the random headers
    logic [MacW-1:0] gw;
    logic [IpW-1:0]  naddr;
    logic [IpW-1:0]  nmask;

    packet_steering_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    packet_steering_classifier_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Timeout with %0d result words outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !(gaps_on && $urandom_range(99) < 33);
        end
    end

    function automatic logic [InDataW-1:0] pack_header(input hdr_t h);
        logic [InDataW-1:0] d;
        d            = '0;
        d[47:0]      = h.dst_mac;
        d[95:48]     = h.src_mac;
        d[127:96]    = h.src_ip;
        d[159:128]   = h.dst_ip;
        d[167:160]   = h.ip_proto;
        d[183:168]   = h.src_port;
        d[199:184]   = h.dst_port;
        d[211:200]   = h.vlan_id;
        d[243:212]   = h.rss_hash;
        d[275:244]   = h.packet_count;
        return d;
    endfunction

    function automatic logic [MacW-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MacW-1:0];
    endfunction

    function automatic logic [IpW-1:0] prefix_mask(input int len);
        return (len == 0) ? '0 : IP_ONES << (IpW - len);
    endfunction

    function automatic logic [MacW-1:0] pick_mac();
        case ($urandom_range(9))
            0:       return MAC_ONES;
            1, 2:    return gw;
            3:       return '0;
            default: return rand_mac();
        endcase
    endfunction

    function automatic logic [IpW-1:0] pick_ip();
        case ($urandom_range(9))
            0:       return IP_ONES;
            1:       return '0;
            2, 3, 4: return naddr | ($urandom() & ~nmask);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(7))
            0:       return 16'hffff;
            1:       return 16'h0000;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic hdr_t random_header();
        hdr_t h;
        h.dst_mac    = pick_mac();
        h.src_mac    = pick_mac();
        h.ip_present = ($urandom_range(99) < 85);
        h.src_ip     = pick_ip();
        h.dst_ip     = pick_ip();
        case ($urandom_range(5))
            0, 1:    h.ip_proto = PROTO_TCP;
            2, 3:    h.ip_proto = PROTO_UDP;
            default: h.ip_proto = 8'($urandom_range(255));
        endcase
        h.l4_present   = ($urandom_range(99) < 70);
        h.src_port     = pick_port();
        h.dst_port     = pick_port();
        h.vlan_id      = ($urandom_range(4) == 0) ? 12'h000 : 12'($urandom_range(12'hfff));
        h.rss_hash     = $urandom();
        h.packet_count = $urandom();
        return h;
    endfunction

    // well-formed header with random content and no broadcast addresses
    function automatic hdr_t plain_header();
        hdr_t h;
        h            = random_header();
        h.dst_mac    = rand_mac() & 48'h7fff_ffff_ffff;
        h.src_mac    = rand_mac() & 48'h7fff_ffff_ffff;
        h.ip_present = 1'b1;
        h.l4_present = 1'b1;
        h.src_ip     = $urandom() & 32'h7fff_ffff;
        h.dst_ip     = $urandom() & 32'h7fff_ffff;
        h.ip_proto   = PROTO_TCP;
        return h;
    endfunction

    task automatic send_header(input hdr_t h);
        while (gaps_on && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_header(h);
        s_tuser  <= {h.l4_present, h.ip_present};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_sent++;
    endtask

    // Caller lowers cfg_we after the last write of a batch.
    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Stop offering words and wait until every result word is out.
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic select_mode(input logic [3:0] m);
        settle();
        write_reg(REG_MODE, CfgDataW'(m));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_directed();
        hdr_t h;
        // reset settings: link mode
        h = plain_header();
        h.dst_mac = '0;
        h.src_mac = '0;
        send_header(h);
        h.dst_mac = MAC_ONES;
        send_header(h);

        settle();
        gw    = 48'h0123_4567_89ab;
        naddr = 32'h0a00_0100;
        nmask = 32'hffff_ff00;
        write_reg(REG_GATEWAY_MAC, gw);
        write_reg(REG_NET_ADDR, CfgDataW'(naddr));
        write_reg(REG_NET_MASK, CfgDataW'(nmask));
        write_reg(REG_SUB_MASK, CfgDataW'(32'hffff_0000));
        write_reg(REG_FIXED_TARGET, CfgDataW'(IP_ONES));
        write_reg(REG_MODE, CfgDataW'(MODE_LOCALLINK));
        cfg_we <= 1'b0;
        n_settings++;
        h = plain_header();
        h.dst_mac = gw;
        send_header(h);
        h = plain_header();
        h.src_mac = gw;
        send_header(h);
        send_header(plain_header());

        select_mode(MODE_DBLMAC);
        h = plain_header();
        h.src_mac = MAC_ONES;
        send_header(h);
        send_header(plain_header());

        select_mode(MODE_VLAN);
        h = plain_header();
        h.vlan_id = 12'h000;
        send_header(h);
        h.vlan_id = 12'hfff;
        send_header(h);

        select_mode(MODE_P2P);
        h = plain_header();
        h.ip_present = 1'b0;
        send_header(h);
        h = plain_header();
        h.dst_ip = IP_ONES;
        send_header(h);

        select_mode(MODE_DBLIP);
        send_header(plain_header());

        select_mode(MODE_LOCALNET);
        h = plain_header();
        h.src_ip = 32'h0a00_0155;
        h.dst_ip = 32'h0a00_01fe;
        send_header(h);
        h.dst_ip = 32'h0b00_0000;
        send_header(h);
        h.src_ip = 32'h0c00_0001;
        h.dst_ip = 32'h0a00_0102;
        send_header(h);
        h.dst_ip = 32'h0000_0000;
        send_header(h);

        select_mode(MODE_FLOW);
        h = plain_header();
        h.l4_present = 1'b0;
        send_header(h);
        h.ip_proto   = PROTO_UDP;
        h.l4_present = 1'b1;
        h.src_port   = 16'hffff;
        h.dst_port   = 16'hffff;
        send_header(h);
        h.ip_proto   = PROTO_ICMP;
        h.l4_present = 1'b0;
        h.src_ip     = IP_ONES;
        send_header(h);

        select_mode(MODE_FIXED);
        send_header(plain_header());
        select_mode(MODE_RSS);
        send_header(plain_header());
        select_mode(MODE_COUNTER);
        send_header(plain_header());
        select_mode(MODE_UNDEF);
        send_header(plain_header());
    endtask

    task automatic random_phase(input int p);
        logic [3:0]     m;
        logic [IpW-1:0] smask;
        logic [IpW-1:0] fixed;
        int             n;
        m = (p < 11) ? 4'(p) : 4'($urandom_range(15));
        case ($urandom_range(3))
            0:       gw = MAC_ONES;
            1:       gw = '0;
            default: gw = rand_mac();
        endcase
        nmask = ($urandom_range(4) == 0) ? $urandom() : prefix_mask($urandom_range(32));
        naddr = ($urandom_range(7) == 0) ? $urandom() : ($urandom() & nmask);
        case ($urandom_range(3))
            0:       smask = IP_ONES;
            1:       smask = '0;
            2:       smask = prefix_mask($urandom_range(32));
            default: smask = $urandom();
        endcase
        case ($urandom_range(3))
            0:       fixed = '0;
            1:       fixed = IP_ONES;
            default: fixed = $urandom();
        endcase
        settle();
        write_reg(REG_GATEWAY_MAC, gw);
        write_reg(REG_NET_ADDR, CfgDataW'(naddr));
        write_reg(REG_NET_MASK, CfgDataW'(nmask));
        write_reg(REG_SUB_MASK, CfgDataW'(smask));
        write_reg(REG_FIXED_TARGET, CfgDataW'(fixed));
        // writes to unused indexes must leave every register alone
        if (p % 3 == 0)
            write_reg(($urandom_range(1) != 0) ? REG_UNUSED_HI : REG_UNUSED_LO,
                      rand_mac());
        write_reg(REG_MODE, CfgDataW'(m));
        cfg_we <= 1'b0;
        n_settings++;
        gaps_on  = (p != 3);
        hold_req = (p == 6);
        n = (p == 3) ? 120 : 45;
        for (int i = 0; i < n; i++)
            send_header(random_header());
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_we     = 1'b0;
        cfg_addr   = REG_MODE;
        cfg_wdata  = '0;
        n_sent     = 0;
        n_settings = 1;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        gw         = '0;
        naddr      = '0;
        nmask      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int p = 0; p < 14; p++)
            random_phase(p);

        settle();
        repeat (8) @(posedge clk);
        $display("Sent %0d headers over %0d register settings, all eleven policies", n_sent,
                 n_settings);
        $display("and undefined modes, with random gaps, a gap-free stretch and a long stall.");
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
